### hw/rtl/lvct_pkg.sv
// ----------------------------------------------------------------------------
// lvct_pkg
// Shared types, constants and defaults for the line voxel cell tracer.
// ----------------------------------------------------------------------------
package lvct_pkg;

  localparam int COORD_W    = 13;
  localparam int CELL_W     = 4;
  localparam int POS_FRAC   = 23;
  localparam int DIR_W      = 16;
  localparam int DIR_ONE    = 16384;
  localparam int SUM_W      = 2 * COORD_W + 2;
  localparam int SQ_W       = 45;
  localparam int LEN_W      = 23;
  localparam int QUO_W      = 15;
  localparam int DIV_PRE    = 22 - QUO_W;
  localparam int SQRT_STEPS = 22;
  localparam int DIV_STEPS  = QUO_W;
  localparam int CNT_W      = 5;

  localparam int NUM_CELLS_DEF   = 16;
  localparam int BOX_SIZE_Q8_DEF = 256;
  localparam int FRAC_BITS_DEF   = 8;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQR,
    ST_SUM,
    ST_CHECK,
    ST_ZERO,
    ST_SQRT,
    ST_DIV_INIT,
    ST_DIV,
    ST_DIV_DONE,
    ST_STEP,
    ST_MARCH
  } lvct_state_e;

  typedef struct packed {
    logic       load;
    logic       square;
    logic       sum;
    logic       sqrt_init;
    logic       sqrt_step;
    logic       div_init;
    logic       div_step;
    logic       div_done;
    logic [1:0] axis;
    logic       step_calc;
    logic       march;
    logic       emit_zero;
  } lvct_cmd_t;

  typedef struct packed {
    logic sum_zero;
    logic out_free;
    logic in_bounds;
  } lvct_status_t;

endpackage

### hw/rtl/lvct_if.sv
// ----------------------------------------------------------------------------
// lvct_if
// Valid/ready channels for segments in and cells out.
// ----------------------------------------------------------------------------
interface lvct_in_if;
  logic                         valid;
  logic                         ready;
  logic [lvct_pkg::COORD_W-1:0] start_x;
  logic [lvct_pkg::COORD_W-1:0] start_y;
  logic [lvct_pkg::COORD_W-1:0] start_z;
  logic [lvct_pkg::COORD_W-1:0] end_x;
  logic [lvct_pkg::COORD_W-1:0] end_y;
  logic [lvct_pkg::COORD_W-1:0] end_z;

  modport source (output valid, start_x, start_y, start_z, end_x, end_y, end_z,
                  input ready);
  modport sink (input valid, start_x, start_y, start_z, end_x, end_y, end_z,
                output ready);
endinterface

interface lvct_out_if;
  logic                        valid;
  logic                        ready;
  logic [lvct_pkg::CELL_W-1:0] cell_x;
  logic [lvct_pkg::CELL_W-1:0] cell_y;
  logic [lvct_pkg::CELL_W-1:0] cell_z;
  logic                        last_cell;
  logic                        no_cells;

  modport source (output valid, cell_x, cell_y, cell_z, last_cell, no_cells,
                  input ready);
  modport sink (input valid, cell_x, cell_y, cell_z, last_cell, no_cells,
                output ready);
endinterface

### hw/rtl/lvct_ctrl.sv
// ----------------------------------------------------------------------------
// lvct_ctrl
// Sequencer: squares, square root, three divisions, then the march, or a zero result for a null segment.
// ----------------------------------------------------------------------------
module lvct_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  lvct_pkg::lvct_status_t status_i,
  output lvct_pkg::lvct_cmd_t    cmd_o
);
  import lvct_pkg::*;

  lvct_state_e      state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [1:0]       axis_q, axis_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      axis_q  <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      axis_q  <= axis_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    axis_d     = axis_q;
    cmd_o      = '0;
    cmd_o.axis = axis_q;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SQR;
        end
      end
      ST_SQR: begin
        cmd_o.square = 1'b1;
        state_d      = ST_SUM;
      end
      ST_SUM: begin
        cmd_o.sum = 1'b1;
        state_d   = ST_CHECK;
      end
      ST_CHECK: begin
        if (status_i.sum_zero) begin
          state_d = ST_ZERO;
        end else begin
          cmd_o.sqrt_init = 1'b1;
          cnt_d           = '0;
          state_d         = ST_SQRT;
        end
      end
      ST_ZERO: begin
        if (status_i.out_free) begin
          cmd_o.emit_zero = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      ST_SQRT: begin
        cmd_o.sqrt_step = 1'b1;
        cnt_d           = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(SQRT_STEPS - 1)) begin
          axis_d  = '0;
          state_d = ST_DIV_INIT;
        end
      end
      ST_DIV_INIT: begin
        cmd_o.div_init = 1'b1;
        cnt_d          = '0;
        state_d        = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
          state_d = ST_DIV_DONE;
        end
      end
      ST_DIV_DONE: begin
        cmd_o.div_done = 1'b1;
        if (axis_q == 2'd2) begin
          state_d = ST_STEP;
        end else begin
          axis_d  = axis_q + 1'b1;
          state_d = ST_DIV_INIT;
        end
      end
      ST_STEP: begin
        cmd_o.step_calc = 1'b1;
        state_d         = ST_MARCH;
      end
      ST_MARCH: begin
        if (status_i.out_free) begin
          cmd_o.march = 1'b1;
          if (!status_i.in_bounds) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

### hw/rtl/lvct_dp.sv
// ----------------------------------------------------------------------------
// lvct_dp
// Datapath: differences, bit-serial square root and division, march
// position registers, pending cell and the output register.
// ----------------------------------------------------------------------------
module lvct_dp #(
  parameter int NUM_CELLS   = lvct_pkg::NUM_CELLS_DEF,
  parameter int BOX_SIZE_Q8 = lvct_pkg::BOX_SIZE_Q8_DEF,
  parameter int FRAC_BITS   = lvct_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  lvct_pkg::lvct_cmd_t                  cmd_i,
  output lvct_pkg::lvct_status_t               status_o,
  input  logic [2:0][lvct_pkg::COORD_W-1:0]    start_i,
  input  logic [2:0][lvct_pkg::COORD_W-1:0]    end_i,
  input  logic                                 out_ready_i,
  output logic                                 out_valid_o,
  output logic [2:0][lvct_pkg::CELL_W-1:0]     cell_o,
  output logic                                 last_o,
  output logic                                 no_cells_o
);
  import lvct_pkg::*;

  localparam int SHIFT = POS_FRAC - FRAC_BITS;
  localparam int RAW_W = COORD_W + SHIFT;
  localparam int POS_W = ((RAW_W > 25) ? RAW_W : 25) + 2;

  logic [COORD_W-1:0]         mag_q [3];
  logic                       neg_q [3];
  logic [2*COORD_W-1:0]       sq_q [3];
  logic [SUM_W-1:0]           sum_q;
  logic [SQ_W-1:0]            v_q, root_q, bit_q;
  logic [LEN_W:0]             rem_q;
  logic [QUO_W-1:0]           quo_q;
  logic signed [DIR_W-1:0]    u_q [3];
  logic signed [POS_W-1:0]    step_q [3];
  logic signed [POS_W-1:0]    start_q [3];
  logic signed [POS_W-1:0]    lo_q [3];
  logic signed [POS_W-1:0]    hi_q [3];
  logic signed [POS_W-1:0]    pos_q [3];
  logic [2:0][CELL_W-1:0]     pend_q;
  logic                       pend_v_q;
  logic                       out_v_q;
  logic [2:0][CELL_W-1:0]     out_cell_q;
  logic                       out_last_q, out_none_q;

  logic [SQ_W-1:0]            sq_t;
  logic                       sq_ge;
  logic [LEN_W:0]             len_ext, rem_sh;
  logic                       div_ge;
  logic [QUO_W-1:0]           quo_sat;
  logic [2:0][CELL_W-1:0]     cell_now;
  logic                       in_b, changed, load_out;

  assign sq_t    = root_q + bit_q;
  assign sq_ge   = v_q >= sq_t;
  assign len_ext = (LEN_W + 1)'(root_q[LEN_W-1:0]);
  assign rem_sh  = {rem_q[LEN_W-1:0], 1'b0};
  assign div_ge  = rem_sh >= len_ext;
  assign quo_sat = (quo_q > QUO_W'(DIR_ONE)) ? QUO_W'(DIR_ONE) : quo_q;

  always_comb begin
    logic [31:0] cfull;
    in_b     = 1'b1;
    cell_now = '0;
    for (int k = 0; k < 3; k++) begin
      if (pos_q[k] < lo_q[k] || pos_q[k] > hi_q[k]) in_b = 1'b0;
      cfull = 32'(pos_q[k][POS_W-1:POS_FRAC]);
      if (cfull > 32'(NUM_CELLS - 1)) cfull = 32'(NUM_CELLS - 1);
      cell_now[k] = cfull[CELL_W-1:0];
    end
  end

  assign changed  = !pend_v_q || (cell_now != pend_q);
  assign load_out = cmd_i.emit_zero || (cmd_i.march && (!in_b || (changed && pend_v_q)));

  assign status_o.sum_zero  = (sum_q == '0);
  assign status_o.out_free  = !out_v_q || out_ready_i;
  assign status_o.in_bounds = in_b;

  // arithmetic and position registers
  always_ff @(posedge clk_i) begin
    logic [POS_W-1:0] sp, ep;
    if (cmd_i.load) begin
      for (int k = 0; k < 3; k++) begin
        sp = POS_W'(start_i[k]) << SHIFT;
        ep = POS_W'(end_i[k]) << SHIFT;
        start_q[k] <= $signed(sp);
        lo_q[k]    <= (sp < ep) ? $signed(sp) : $signed(ep);
        hi_q[k]    <= (sp < ep) ? $signed(ep) : $signed(sp);
        neg_q[k]   <= end_i[k] < start_i[k];
        mag_q[k]   <= (end_i[k] < start_i[k]) ? start_i[k] - end_i[k]
                                              : end_i[k] - start_i[k];
      end
    end
    if (cmd_i.square) begin
      for (int k = 0; k < 3; k++) begin
        sq_q[k] <= (2*COORD_W)'(mag_q[k]) * (2*COORD_W)'(mag_q[k]);
      end
    end
    if (cmd_i.sum) begin
      sum_q <= SUM_W'(sq_q[0]) + SUM_W'(sq_q[1]) + SUM_W'(sq_q[2]);
    end
    if (cmd_i.sqrt_init) begin
      v_q    <= SQ_W'(sum_q) << 16;
      root_q <= '0;
      bit_q  <= SQ_W'(1) << (2 * (SQRT_STEPS - 1));
    end
    if (cmd_i.sqrt_step) begin
      if (sq_ge) begin
        v_q    <= v_q - sq_t;
        root_q <= (root_q >> 1) + bit_q;
      end else begin
        root_q <= root_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
    if (cmd_i.div_init) begin
      rem_q <= (LEN_W + 1)'(mag_q[cmd_i.axis]) << DIV_PRE;
      quo_q <= '0;
    end
    if (cmd_i.div_step) begin
      rem_q <= div_ge ? rem_sh - len_ext : rem_sh;
      quo_q <= {quo_q[QUO_W-2:0], div_ge};
    end
    if (cmd_i.div_done) begin
      u_q[cmd_i.axis] <= neg_q[cmd_i.axis] ? -$signed(DIR_W'(quo_sat))
                                           : $signed(DIR_W'(quo_sat));
    end
    if (cmd_i.step_calc) begin
      for (int k = 0; k < 3; k++) begin
        step_q[k] <= $signed(POS_W'(u_q[k])) * $signed(POS_W'(BOX_SIZE_Q8));
        pos_q[k]  <= start_q[k];
      end
    end
    if (cmd_i.march && in_b) begin
      for (int k = 0; k < 3; k++) begin
        pos_q[k] <= pos_q[k] + step_q[k];
      end
      if (changed) pend_q <= cell_now;
    end
    if (load_out) begin
      out_cell_q <= cmd_i.emit_zero ? '0 : pend_q;
      out_last_q <= cmd_i.emit_zero || !in_b;
      out_none_q <= cmd_i.emit_zero;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      if (cmd_i.step_calc) begin
        pend_v_q <= 1'b0;
      end else if (cmd_i.march && in_b) begin
        pend_v_q <= 1'b1;
      end
      if (load_out) begin
        out_v_q <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_v_q;
  assign cell_o      = out_cell_q;
  assign last_o      = out_last_q;
  assign no_cells_o  = out_none_q;

endmodule

### hw/rtl/line_voxel_cell_tracer.sv
// ----------------------------------------------------------------------------
// line_voxel_cell_tracer
// Lists the grid cells that a line segment passes through, in walk order.
// ----------------------------------------------------------------------------
// One segment is taken at a time. The differences are formed on the accepting
// edge; after that the block forms the squares and their sum, does the zero
// check, runs the bit-serial square root and then, axis by axis, the shared
// restoring divider, and sets up the step. It then marches one half-box step
// per cycle until the walk leaves the segment bounds; the march step that
// finds the walk outside delivers the final cell. Cycles where the output
// register is still full stall the march. A zero-length segment skips the
// root and the divisions and puts its one result out from the zero state.
module line_voxel_cell_tracer #(
  parameter int NUM_CELLS   = lvct_pkg::NUM_CELLS_DEF,
  parameter int BOX_SIZE_Q8 = lvct_pkg::BOX_SIZE_Q8_DEF,
  parameter int FRAC_BITS   = lvct_pkg::FRAC_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  lvct_in_if.sink     in_i,
  lvct_out_if.source  out_o
);
  import lvct_pkg::*;

  lvct_cmd_t              cmd;
  lvct_status_t           status;
  logic [2:0][COORD_W-1:0] start_v, end_v;
  logic [2:0][CELL_W-1:0]  cell_v;

  assign start_v = {in_i.start_z, in_i.start_y, in_i.start_x};
  assign end_v   = {in_i.end_z, in_i.end_y, in_i.end_x};

  lvct_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  lvct_dp #(
    .NUM_CELLS   (NUM_CELLS),
    .BOX_SIZE_Q8 (BOX_SIZE_Q8),
    .FRAC_BITS   (FRAC_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .start_i     (start_v),
    .end_i       (end_v),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .cell_o      (cell_v),
    .last_o      (out_o.last_cell),
    .no_cells_o  (out_o.no_cells)
  );

  assign out_o.cell_x = cell_v[0];
  assign out_o.cell_y = cell_v[1];
  assign out_o.cell_z = cell_v[2];

  // a zero-length result is the only one and carries a zero cell
  a_no_cells_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.no_cells |->
      out_o.last_cell && out_o.cell_x == '0 && out_o.cell_y == '0 &&
      out_o.cell_z == '0)
    else $error("no_cells result malformed");

  // a transfer in starts work, so the input side closes next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> !in_i.ready)
    else $error("input taken while busy");

  // the output register is never overwritten while it holds an untaken cell
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.march || cmd.emit_zero) |-> (!out_o.valid || out_o.ready))
    else $error("output register overwritten");

endmodule

### verif/tb_line_voxel_cell_tracer.sv
// ----------------------------------------------------------------------------
// tb_line_voxel_cell_tracer
// Sends line segments through the cell tracer and checks every listed cell
// against a fixed-point cell walk computed in the testbench or, for typed rows, a fixed cell.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_line_voxel_cell_tracer;
  import lvct_pkg::*;

  localparam int NCELL    = NUM_CELLS_DEF;
  localparam int BOX_Q8   = BOX_SIZE_Q8_DEF;
  localparam int FBITS    = FRAC_BITS_DEF;
  localparam int MAX_OUT  = 3 * (NCELL - 1) + 1;
  localparam int WDOG_MAX = 20000;

  typedef struct packed {
    logic [COORD_W-1:0] sx, sy, sz, ex, ey, ez;
  } segment_t;

  typedef struct packed {
    logic [CELL_W-1:0] cx, cy, cz;
    logic              last_cell;
    logic              no_cells;
  } cell_t;

  typedef struct {
    segment_t seg;
    bit       has_exp;
    cell_t    exp_cell;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  lvct_in_if  seg_if ();
  lvct_out_if cell_if ();

  line_voxel_cell_tracer uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (seg_if.sink),
    .out_o (cell_if.source)
  );

  always #5 clk_i = ~clk_i;

  cell_t       cells_due[$];
  int          errors = 0;
  int          segs_sent = 0;
  int          cells_seen = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          hold_off = 0;
  int          wdog = 0;

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v    -= root + bitv;
        root  = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  function automatic logic [CELL_W-1:0] pos_to_cell(longint p);
    longint c;
    c = (p < 0) ? 0 : (p >>> POS_FRAC);
    if (c > NCELL - 1) c = NCELL - 1;
    return c[CELL_W-1:0];
  endfunction

  function automatic void queue_cell(cell_t cl);
    cells_due = {cells_due, cl};
  endfunction

  // walks the segment and queues every new cell it enters, up to MAX_OUT; a null segment queues one no_cells result
  task automatic trace_segment(segment_t sg);
    longint          st[3], en[3], d[3], u[3], p[3], lo, hi;
    longint unsigned sum, len, mag, q;
    logic [CELL_W-1:0] c[3], prev[3];
    bit    have, inb;
    int    n;
    cell_t cl;
    st[0] = sg.sx; st[1] = sg.sy; st[2] = sg.sz;
    en[0] = sg.ex; en[1] = sg.ey; en[2] = sg.ez;
    sum = 0;
    for (int k = 0; k < 3; k++) begin
      d[k] = en[k] - st[k];
      sum += d[k] * d[k];
    end
    if (sum == 0) begin
      cl = '{cx: '0, cy: '0, cz: '0, last_cell: 1'b1, no_cells: 1'b1};
      queue_cell(cl);
      return;
    end
    len = int_sqrt(sum << 16);
    for (int k = 0; k < 3; k++) begin
      mag = (d[k] < 0) ? -d[k] : d[k];
      q = (mag << 22) / len;
      if (q > DIR_ONE) q = DIR_ONE;
      u[k] = (d[k] < 0) ? -longint'(q) : longint'(q);
      st[k] = st[k] << (POS_FRAC - FBITS);
      en[k] = en[k] << (POS_FRAC - FBITS);
      p[k] = st[k];
    end
    have = 0;
    n = 0;
    forever begin
      inb = 1;
      for (int k = 0; k < 3; k++) begin
        lo = (st[k] < en[k]) ? st[k] : en[k];
        hi = (st[k] < en[k]) ? en[k] : st[k];
        if (p[k] < lo || p[k] > hi) inb = 0;
      end
      if (!inb) break;
      for (int k = 0; k < 3; k++) begin
        c[k] = pos_to_cell(p[k]);
        p[k] += u[k] * BOX_Q8;
      end
      if (!have || c[0] != prev[0] || c[1] != prev[1] || c[2] != prev[2]) begin
        if (n < MAX_OUT) begin
          cl = '{cx: c[0], cy: c[1], cz: c[2], last_cell: 1'b0, no_cells: 1'b0};
          queue_cell(cl);
          n++;
        end
        prev = c;
        have = 1;
      end
    end
    if (n > 0) cells_due[$].last_cell = 1'b1;
  endtask

  // receiver side: stalls and the long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_if.ready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off      <= hold_off - 1;
      cell_if.ready <= 1'b0;
    end else begin
      cell_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // result checker
  always @(posedge clk_i) begin
    cell_t got, want;
    if (rst_ni && cell_if.valid && cell_if.ready) begin
      got = '{cx: cell_if.cell_x, cy: cell_if.cell_y, cz: cell_if.cell_z,
              last_cell: cell_if.last_cell, no_cells: cell_if.no_cells};
      cells_seen++;
      if (cells_due.size() == 0) begin
        $error("cell transfer with nothing expected");
        errors++;
      end else begin
        want = cells_due.pop_front();
        if (got.cx != want.cx) begin
          $error("cell_x exp %0d got %0d", want.cx, got.cx); errors++;
        end
        if (got.cy != want.cy) begin
          $error("cell_y exp %0d got %0d", want.cy, got.cy); errors++;
        end
        if (got.cz != want.cz) begin
          $error("cell_z exp %0d got %0d", want.cz, got.cz); errors++;
        end
        if (got.last_cell != want.last_cell) begin
          $error("last_cell exp %0d got %0d", want.last_cell, got.last_cell);
          errors++;
        end
        if (got.no_cells != want.no_cells) begin
          $error("no_cells exp %0d got %0d", want.no_cells, got.no_cells);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((seg_if.valid && seg_if.ready) || (cell_if.valid && cell_if.ready)) begin
      wdog <= 0;
    end else begin
      wdog <= wdog + 1;
      if (wdog >= WDOG_MAX) begin
        $display("watchdog expired, %0d cells outstanding", cells_due.size());
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  function automatic logic [COORD_W-1:0] rand_coord(bit wide);
    if (wide) return COORD_W'($urandom_range(2 ** COORD_W - 1));
    return COORD_W'($urandom_range(4096));
  endfunction

  // one segment transfer, with random idle cycles ahead of it; valid is left
  // high so the next segment can follow right away
  task automatic send_segment(segment_t sg, bit typed, cell_t exp_cell);
    while ($urandom_range(99) < send_idle_pct) begin
      seg_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    seg_if.valid   <= 1'b1;
    seg_if.start_x <= sg.sx; seg_if.start_y <= sg.sy; seg_if.start_z <= sg.sz;
    seg_if.end_x   <= sg.ex; seg_if.end_y   <= sg.ey; seg_if.end_z   <= sg.ez;
    if (typed) queue_cell(exp_cell);
    else trace_segment(sg);
    segs_sent++;
    do @(posedge clk_i); while (!seg_if.ready);
  endtask

  task automatic drain();
    seg_if.valid <= 1'b0;
    while (cells_due.size() != 0) @(posedge clk_i);
  endtask

  function automatic segment_t random_segment();
    segment_t sg;
    bit wide;
    int r;
    wide = ($urandom_range(9) == 0);
    sg = '{rand_coord(wide), rand_coord(wide), rand_coord(wide),
           rand_coord(wide), rand_coord(wide), rand_coord(wide)};
    r = $urandom_range(9);
    // half the segments are short to keep the march brief; some axis-aligned or null
    if (r < 5) begin
      sg.ex = COORD_W'(sg.sx + $urandom_range(1024) - 512);
      sg.ey = COORD_W'(sg.sy + $urandom_range(1024) - 512);
      sg.ez = COORD_W'(sg.sz + $urandom_range(1024) - 512);
    end else if (r == 5) begin
      sg.ey = sg.sy; sg.ez = sg.sz;
    end else if (r == 6) begin
      sg.ex = sg.sx; sg.ey = sg.sy; sg.ez = sg.sz;
    end
    return sg;
  endfunction

  dir_row_t dir_rows[] = '{
    '{'{13'd0, 13'd0, 13'd0, 13'd0, 13'd0, 13'd0}, 1,
      '{4'd0, 4'd0, 4'd0, 1'b1, 1'b1}},
    '{'{13'd4096, 13'd4096, 13'd4096, 13'd4096, 13'd4096, 13'd4096}, 1,
      '{4'd0, 4'd0, 4'd0, 1'b1, 1'b1}},
    '{'{13'h1FFF, 13'h1FFF, 13'h1FFF, 13'h1FFF, 13'h1FFF, 13'h1FFF}, 1,
      '{4'd0, 4'd0, 4'd0, 1'b1, 1'b1}},
    '{'{13'd0, 13'd0, 13'd0, 13'd1, 13'd0, 13'd0}, 1,
      '{4'd0, 4'd0, 4'd0, 1'b1, 1'b0}},
    '{'{13'd0, 13'd0, 13'd0, 13'd4096, 13'd4096, 13'd4096}, 0, '0},
    '{'{13'd4096, 13'd4096, 13'd4096, 13'd0, 13'd0, 13'd0}, 0, '0},
    '{'{13'd0, 13'd0, 13'd0, 13'h1FFF, 13'd0, 13'd0}, 0, '0},
    '{'{13'h1FFF, 13'h1FFF, 13'h1FFF, 13'd0, 13'd0, 13'd0}, 0, '0},
    '{'{13'd0, 13'd0, 13'd0, 13'd0, 13'd4096, 13'd0}, 0, '0},
    '{'{13'd0, 13'd0, 13'd4096, 13'd0, 13'd0, 13'd0}, 0, '0},
    '{'{13'd128, 13'd3968, 13'd100, 13'd3968, 13'd128, 13'd2000}, 0, '0},
    '{'{13'd255, 13'd256, 13'd257, 13'd256, 13'd255, 13'd511}, 0, '0},
    '{'{13'h0AAA, 13'h1555, 13'h0AAA, 13'h1555, 13'h0AAA, 13'h1555}, 0, '0},
    '{'{13'd4000, 13'd10, 13'd2048, 13'd4001, 13'd10, 13'd2048}, 0, '0}
  };

  initial begin
    seg_if.valid   = 1'b0;
    seg_if.start_x = '0; seg_if.start_y = '0; seg_if.start_z = '0;
    seg_if.end_x   = '0; seg_if.end_y   = '0; seg_if.end_z   = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed rows; typed rows expect their fixed cell, the rest the walk
    foreach (dir_rows[i]) begin
      send_segment(dir_rows[i].seg, dir_rows[i].has_exp, dir_rows[i].exp_cell);
    end
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
        default: begin send_idle_pct = 31; recv_stall_pct = 31; end
      endcase
      if (ph == 0) hold_off = 400;
      for (int n = 0; n < 36; n++) send_segment(random_segment(), 1'b0, '0);
      // sender pauses until every cell is back
      drain();
    end

    drain();
    repeat (200) @(posedge clk_i);
    $display("%0d segments traced, %0d cells checked over four idle/stall mixes",
             segs_sent, cells_seen);
    if (errors == 0 && cells_due.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
